// ===== design/life_automaton_torus_step_top_assert.svh =====
// Assertion helpers for the grid block; clk and rst_n come from the
// module that uses them.
`ifndef LIFE_AUTOMATON_TORUS_STEP_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_STEP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LAT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LAT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/lat_pkg.sv =====
package lat_pkg;

  localparam int MAX_DIM_DEF = 64;

  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;
  localparam int COUNT_W = 4;

  // B3/S23 neighbour counts
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;

  typedef enum logic [1:0] {
    OP_TOGGLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_STEP   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic {
    REG_GRID_ROWS    = 1'b0,
    REG_GRID_COLUMNS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic clr;
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== design/lat_row_mem.sv =====
module lat_row_mem #(
  parameter int MAX_DIM = lat_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lat_pkg::mem_ctl_t          ctl,
  input  logic [$clog2(MAX_DIM)-1:0] wr_addr,
  input  logic [MAX_DIM-1:0]         wr_row,
  input  logic [$clog2(MAX_DIM)-1:0] rd_addr,
  output logic [MAX_DIM-1:0]         rd_row
);

  logic [MAX_DIM-1:0] mem [MAX_DIM];
  logic [MAX_DIM-1:0] row_q;
  logic [MAX_DIM-1:0] valid_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      row_q <= mem[rd_addr];
    end
  end

  // A row that was never written since reset or clear reads as all dead.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_row = rd_valid_r ? row_q : '0;

endmodule

// ===== design/lat_row_update.sv =====
module lat_row_update #(
  parameter int MAX_DIM = lat_pkg::MAX_DIM_DEF
) (
  input  logic [MAX_DIM-1:0]           up_row,
  input  logic [MAX_DIM-1:0]           cur_row,
  input  logic [MAX_DIM-1:0]           dn_row,
  input  logic [$clog2(MAX_DIM+1)-1:0] cols_used,
  output logic [MAX_DIM-1:0]           nxt_row
);

  localparam int IDX_W = $clog2(MAX_DIM);

  logic [IDX_W-1:0] last_col;

  assign last_col = IDX_W'(cols_used - 1'b1);

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
    logic [IDX_W-1:0]                 li;
    logic [IDX_W-1:0]                 ri;
    logic [lat_pkg::COUNT_W-1:0]      n;
    logic                             rule;

    if (c == 0) begin : g_left_wrap
      assign li = last_col;
    end else begin : g_left
      assign li = IDX_W'(c - 1);
    end

    if (c == MAX_DIM - 1) begin : g_right_wrap
      assign ri = '0;
    end else begin : g_right
      assign ri = (last_col == IDX_W'(c)) ? '0 : IDX_W'(c + 1);
    end

    // Wrapped positions may name the same cell twice on narrow grids.
    assign n = lat_pkg::COUNT_W'(up_row[li]) + lat_pkg::COUNT_W'(up_row[c])
             + lat_pkg::COUNT_W'(up_row[ri]) + lat_pkg::COUNT_W'(cur_row[li])
             + lat_pkg::COUNT_W'(cur_row[ri]) + lat_pkg::COUNT_W'(dn_row[li])
             + lat_pkg::COUNT_W'(dn_row[c]) + lat_pkg::COUNT_W'(dn_row[ri]);

    assign rule = cur_row[c]
                ? ((n == lat_pkg::SURVIVE_COUNT) || (n == lat_pkg::BIRTH_COUNT))
                : (n == lat_pkg::BIRTH_COUNT);

    assign nxt_row[c] = (32'(c) < 32'(cols_used)) ? rule : cur_row[c];
  end

endmodule

// ===== design/life_automaton_torus_step_top.sv =====
// Game of Life (B3/S23) on a wrapping grid of up to MAX_DIM x MAX_DIM cells.
// Input stream: in_tuser carries the opcode (toggle, clear, step, read),
// in_tdata the cell row and column. Every transaction yields exactly one
// result transaction on out_*: the addressed cell after the operation
// (0 when the address lies outside the grid in use).
// Config: cfg_index 0 sets the row count, 1 the column count; write only
// while the block is idle, and clear the grid after a size change.
// Cells live one grid row per memory word; a step streams the rows through
// three row registers and writes back one updated row per cycle.
// Order of work: toggle and read pass through S_RD and S_OP to S_RESP; clear
// goes straight to S_RESP; a step runs S_UP, S_CUR and S_PRE (prefetch of the
// wrapped top row), the memory read/write loop in S_ROW, then S_RD, S_OP, S_RESP.
// One item is worked on at a time; a new item is accepted as soon as the
// previous one has left the working states, even while its result still
// waits in the output register. A stalled output holds its result and the
// block waits before finishing the next item.
// Reset sets both size registers to 1 and marks every row dead at once
// through per-row valid bits; no clearing pass is needed.
module life_automaton_torus_step_top #(
  parameter int MAX_DIM = lat_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] cell_row, [11:6] cell_column
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] cell_alive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int UW    = $clog2(MAX_DIM + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_OP   = 8'b0000_0100,
    S_UP   = 8'b0000_1000,
    S_CUR  = 8'b0001_0000,
    S_PRE  = 8'b0010_0000,
    S_ROW  = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [lat_pkg::CFG_W-1:0]   grid_rows_r;
  logic [lat_pkg::CFG_W-1:0]   grid_columns_r;
  logic [UW-1:0]               rows_used;
  logic [UW-1:0]               cols_used;

  lat_pkg::op_t                op_r, op_nxt;
  logic [lat_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [lat_pkg::COORD_W-1:0] col_r, col_nxt;
  logic                        in_grid;
  logic                        res_r, res_nxt;
  logic [IDX_W-1:0]            r_r, r_nxt;
  logic [MAX_DIM-1:0]          up_r, up_nxt;
  logic [MAX_DIM-1:0]          cur_r, cur_nxt;
  logic [MAX_DIM-1:0]          first_r, first_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_bit_r, out_bit_nxt;

  lat_pkg::mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]            wr_addr;
  logic [MAX_DIM-1:0]          wr_row;
  logic [IDX_W-1:0]            rd_addr;
  logic [MAX_DIM-1:0]          rd_row;
  logic [MAX_DIM-1:0]          dn_row;
  logic [MAX_DIM-1:0]          upd_row;
  logic                        last_row;
  logic                        in_fire;
  logic                        rd_bit;

  function automatic logic [UW-1:0] used_size(input logic [lat_pkg::CFG_W-1:0] v);
    logic [UW-1:0] s;
    if (v == '0) begin
      s = UW'(1);
    end else if (32'(v) > MAX_DIM) begin
      s = UW'(MAX_DIM);
    end else begin
      s = UW'(v);
    end
    return s;
  endfunction

  assign rows_used = used_size(grid_rows_r);
  assign cols_used = used_size(grid_columns_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r    <= lat_pkg::CFG_W'(1);
      grid_columns_r <= lat_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (lat_pkg::reg_idx_t'(cfg_index))
        lat_pkg::REG_GRID_ROWS:    grid_rows_r    <= cfg_data;
        lat_pkg::REG_GRID_COLUMNS: grid_columns_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign in_grid = (32'(row_r) < 32'(rows_used)) && (32'(col_r) < 32'(cols_used));

  assign last_row = (32'(r_r) == 32'(rows_used) - 32'd1);
  // The bottom row wraps to row 0, already overwritten; use its saved copy.
  assign dn_row   = last_row ? first_r : rd_row;
  assign rd_bit   = rd_row[IDX_W'(col_r)];

  lat_row_mem #(
    .MAX_DIM(MAX_DIM)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .wr_row (wr_row),
    .rd_addr(rd_addr),
    .rd_row (rd_row)
  );

  lat_row_update #(
    .MAX_DIM(MAX_DIM)
  ) u_update (
    .up_row   (up_r),
    .cur_row  (cur_r),
    .dn_row   (dn_row),
    .cols_used(cols_used),
    .nxt_row  (upd_row)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    res_nxt       = res_r;
    r_nxt         = r_r;
    up_nxt        = up_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    mem_ctl       = '0;
    wr_addr       = r_r;
    wr_row        = upd_row;
    rd_addr       = IDX_W'(row_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt  = lat_pkg::op_t'(in_tuser);
          row_nxt = in_tdata[5:0];
          col_nxt = in_tdata[11:6];
          unique case (lat_pkg::op_t'(in_tuser))
            lat_pkg::OP_CLEAR: begin
              mem_ctl.clr = 1'b1;
              res_nxt     = 1'b0;
              state_nxt   = S_RESP;
            end
            lat_pkg::OP_STEP: state_nxt = S_UP;
            default:          state_nxt = S_RD;
          endcase
        end
      end
      S_UP: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = IDX_W'(rows_used - 1'b1);
        state_nxt     = S_CUR;
      end
      S_CUR: begin
        up_nxt        = rd_row;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = '0;
        state_nxt     = S_PRE;
      end
      S_PRE: begin
        cur_nxt       = rd_row;
        first_nxt     = rd_row;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = IDX_W'(1);
        r_nxt         = '0;
        state_nxt     = S_ROW;
      end
      S_ROW: begin
        // Write row r while fetching row r + 2, the next row's lower neighbour.
        mem_ctl.wr_en = 1'b1;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = IDX_W'(32'(r_r) + 32'd2);
        up_nxt        = cur_r;
        cur_nxt       = dn_row;
        r_nxt         = r_r + 1'b1;
        if (last_row) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = IDX_W'(row_r);
        state_nxt     = S_OP;
      end
      S_OP: begin
        wr_addr = IDX_W'(row_r);
        wr_row  = rd_row ^ (MAX_DIM'(1) << IDX_W'(col_r));
        if (op_r == lat_pkg::OP_TOGGLE) begin
          mem_ctl.wr_en = in_grid;
          res_nxt       = in_grid && !rd_bit;
        end else begin
          res_nxt = in_grid && rd_bit;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    res_r     <= res_nxt;
    r_r       <= r_nxt;
    up_r      <= up_nxt;
    cur_r     <= cur_nxt;
    first_r   <= first_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

`include "life_automaton_torus_step_top_assert.svh"

  `LAT_ASSERT_NXT(a_accept_starts_work, in_fire, state_r != S_IDLE)
  `LAT_ASSERT_IMP(a_row_in_grid, state_r == S_ROW, 32'(r_r) < 32'(rows_used))
  `LAT_ASSERT_NXT(a_result_waits, (state_r == S_RESP) && out_valid_r && !out_tready,
                  (state_r == S_RESP) && out_valid_r)

endmodule
